// ----- hw/rtl/u16u8_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the UTF-16LE to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

	localparam int unsigned MAX_SLOT_UNITS_DEF = 512;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned POS_W = 9;
	localparam int unsigned CP_W = 21;

	localparam logic [5:0] HIGH_PREFIX = 6'b110110;
	localparam logic [5:0] LOW_PREFIX = 6'b110111;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_UNPAIRED_LOW = 2'd1,
		ST_MISSING_LOW = 2'd2,
		ST_TRUNCATED_HIGH = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic slot_end;
	} unit_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic string_done;
		status_t status;
		logic [POS_W-1:0] error_position;
		logic last;
	} byte_word_t;

	typedef struct packed {
		logic is_marker;
		logic [CP_W-1:0] cp;
		logic end_flag;
		status_t status;
		logic [POS_W-1:0] pos;
	} cmd_t;

endpackage

// ----- hw/rtl/u16u8_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts code units, pairs surrogates, tracks slot state, issues commands.
// Depends on u16u8_pkg.
module u16u8_front #(
	parameter int unsigned MAX_SLOT_UNITS = u16u8_pkg::MAX_SLOT_UNITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input u16u8_pkg::unit_word_t word,
	output logic push,
	output u16u8_pkg::cmd_t cmd
);

	logic high_pending_q;
	logic [9:0] high_bits_q;
	logic skipping_q;
	logic [u16u8_pkg::POS_W-1:0] unit_index_q;

	logic is_high;
	logic is_low;
	logic end_eff;
	logic stop;
	logic emit;
	logic hold_high;

	always_comb begin
		is_high = (word.code_unit[15:10] == u16u8_pkg::HIGH_PREFIX);
		is_low = (word.code_unit[15:10] == u16u8_pkg::LOW_PREFIX);
		end_eff = word.slot_end
			| ((32'(unit_index_q) + 32'd1) >= 32'(MAX_SLOT_UNITS));
		stop = 1'b0;
		emit = 1'b0;
		hold_high = 1'b0;
		cmd.is_marker = 1'b0;
		cmd.cp = {5'd0, word.code_unit};
		cmd.end_flag = end_eff;
		cmd.status = u16u8_pkg::ST_OK;
		cmd.pos = '0;
		priority if (skipping_q) begin
			emit = 1'b0;
		end else if (high_pending_q) begin
			emit = 1'b1;
			if (is_low) begin
				cmd.cp = {1'b0, high_bits_q, word.code_unit[9:0]} + u16u8_pkg::SUPP_BASE;
			end else begin
				cmd.is_marker = 1'b1;
				cmd.status = u16u8_pkg::ST_MISSING_LOW;
				cmd.pos = unit_index_q - 9'd1;
				stop = 1'b1;
			end
		end else if (word.code_unit == 16'd0) begin
			emit = 1'b1;
			cmd.is_marker = 1'b1;
			stop = 1'b1;
		end else if (is_high) begin
			if (end_eff) begin
				emit = 1'b1;
				cmd.is_marker = 1'b1;
				cmd.status = u16u8_pkg::ST_TRUNCATED_HIGH;
				cmd.pos = unit_index_q;
				stop = 1'b1;
			end else begin
				hold_high = 1'b1;
			end
		end else if (is_low) begin
			emit = 1'b1;
			cmd.is_marker = 1'b1;
			cmd.status = u16u8_pkg::ST_UNPAIRED_LOW;
			cmd.pos = unit_index_q;
			stop = 1'b1;
		end else begin
			emit = 1'b1;
		end
		push = accept & emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			high_bits_q <= '0;
			skipping_q <= 1'b0;
			unit_index_q <= '0;
		end else if (accept) begin
			if (end_eff) begin
				high_pending_q <= 1'b0;
				high_bits_q <= '0;
				skipping_q <= 1'b0;
				unit_index_q <= '0;
			end else begin
				if (!skipping_q) begin
					high_pending_q <= hold_high;
				end
				if (hold_high) begin
					high_bits_q <= word.code_unit[9:0];
				end
				if (stop) begin
					skipping_q <= 1'b1;
				end
				unit_index_q <= unit_index_q + 9'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/u16u8_queue.sv -----
`timescale 1ns / 1ps
// Command queue between front and back ends.
// Depends on u16u8_pkg.
module u16u8_queue #(
	parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input u16u8_pkg::cmd_t push_cmd,
	input logic pop,
	output u16u8_pkg::cmd_t head,
	output logic nonempty,
	output logic full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	u16u8_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign nonempty = (count_q != '0);
	assign full = (count_q == CNT_FULL);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/u16u8_back.sv -----
`timescale 1ns / 1ps
// Back end: serializes one command into UTF-8 bytes or a marker word.
// Depends on u16u8_pkg.
module u16u8_back (
	input logic clk,
	input logic arst_n,
	input u16u8_pkg::cmd_t head,
	input logic nonempty,
	output logic pop,
	output logic valid,
	input logic stall,
	output u16u8_pkg::byte_word_t data
);

	u16u8_pkg::cmd_t cmd_q;
	logic busy_q;
	logic [1:0] idx_q;
	logic [1:0] len_m1;
	logic last_byte;
	logic fire;
	logic [7:0] enc_byte;

	always_comb begin
		if (cmd_q.cp <= 21'h7f) begin
			len_m1 = 2'd0;
		end else if (cmd_q.cp <= 21'h7ff) begin
			len_m1 = 2'd1;
		end else if (cmd_q.cp <= 21'hffff) begin
			len_m1 = 2'd2;
		end else begin
			len_m1 = 2'd3;
		end
		enc_byte = 8'h00;
		unique case (len_m1)
			2'd0: enc_byte = {1'b0, cmd_q.cp[6:0]};
			2'd1: enc_byte = (idx_q == 2'd0) ? {3'b110, cmd_q.cp[10:6]}
				: {2'b10, cmd_q.cp[5:0]};
			2'd2: begin
				unique case (idx_q)
					2'd0: enc_byte = {4'b1110, cmd_q.cp[15:12]};
					2'd1: enc_byte = {2'b10, cmd_q.cp[11:6]};
					default: enc_byte = {2'b10, cmd_q.cp[5:0]};
				endcase
			end
			default: begin
				unique case (idx_q)
					2'd0: enc_byte = {5'b11110, cmd_q.cp[20:18]};
					2'd1: enc_byte = {2'b10, cmd_q.cp[17:12]};
					2'd2: enc_byte = {2'b10, cmd_q.cp[11:6]};
					default: enc_byte = {2'b10, cmd_q.cp[5:0]};
				endcase
			end
		endcase
		last_byte = cmd_q.is_marker | (idx_q == len_m1);
		fire = busy_q & ~stall;
		pop = nonempty & (~busy_q | (fire & last_byte));
		valid = busy_q;
		if (cmd_q.is_marker) begin
			data.out_byte = 8'h00;
			data.byte_valid = 1'b0;
			data.string_done = 1'b1;
			data.status = cmd_q.status;
			data.error_position = cmd_q.pos;
			data.last = 1'b1;
		end else begin
			data.out_byte = enc_byte;
			data.byte_valid = 1'b1;
			data.string_done = last_byte & cmd_q.end_flag;
			data.status = u16u8_pkg::ST_OK;
			data.error_position = '0;
			data.last = last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (fire) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ----- hw/rtl/utf16le_to_utf8_transcoder.sv -----
`timescale 1ns / 1ps
// A command is registered in the queue, then in the back-end command register.
// Throughput: one output word per cycle unless stalled or empty; a unit gives 1 to 4
// words (bytes of its code point, one for a marker), serialized by the back end.
// Held high surrogates and ignored units produce no output.
// Reset (arst_n low) clears surrogate, skip and index state and empties the queue.
module utf16le_to_utf8_transcoder #(
	parameter int unsigned MAX_SLOT_UNITS = u16u8_pkg::MAX_SLOT_UNITS_DEF,
	parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	output logic src_stall,
	input u16u8_pkg::unit_word_t src_data,
	output logic dst_valid,
	input logic dst_stall,
	output u16u8_pkg::byte_word_t dst_data
);

	logic accept;
	logic push;
	logic pop;
	logic nonempty;
	logic full;
	u16u8_pkg::cmd_t push_cmd;
	u16u8_pkg::cmd_t head;

	assign src_stall = full;
	assign accept = src_valid & ~full;

	u16u8_front #(
		.MAX_SLOT_UNITS(MAX_SLOT_UNITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.word(src_data),
		.push(push),
		.cmd(push_cmd)
	);

	u16u8_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head(head),
		.nonempty(nonempty),
		.full(full)
	);

	u16u8_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.nonempty(nonempty),
		.pop(pop),
		.valid(dst_valid),
		.stall(dst_stall),
		.data(dst_data)
	);

endmodule

// ----- hw/rtl/u16u8_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the transcoder, bound to the top level.
// Depends on u16u8_pkg and utf16le_to_utf8_transcoder.
module u16u8_checker (
	input logic clk,
	input logic arst_n,
	input logic dst_valid,
	input logic dst_stall,
	input u16u8_pkg::byte_word_t dst_data
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("output word changed while stalled");

	a_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_data.byte_valid |-> dst_data.string_done && dst_data.last)
		else $error("marker word without done and last");

	a_error_marker: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.status != u16u8_pkg::ST_OK |-> !dst_data.byte_valid)
		else $error("error status on a byte word");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.byte_valid
		|-> dst_data.error_position == '0 && dst_data.status == u16u8_pkg::ST_OK)
		else $error("byte word carries error fields");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.string_done |-> dst_data.last)
		else $error("string done before final byte of unit");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.dst_valid(dst_valid),
	.dst_stall(dst_stall),
	.dst_data(dst_data)
);
